[hw/rtl/sps_pkg.sv]
// sps_pkg: shared types and constants of the segmented prime sieve
// no dependencies; used by the channel interfaces, the remainder unit and the top level

package sps_pkg;

    localparam int BASE_W   = 34;   // segment base width
    localparam int LENGTH_W = 17;   // segment length register width
    localparam int PRIME_W  = 17;   // root prime width
    localparam int COUNT_W  = 17;   // prime count field width
    localparam int WIDE_W   = 35;   // start and offset arithmetic
    localparam int WORD_W   = 32;   // bits per map word
    localparam int WBIT_W   = 5;    // bit select within a map word
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 1'd1;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 17'd65536;

    typedef struct packed {
        logic start;
    } rem_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_sts_t;

endpackage

[hw/rtl/sps_if.sv]
// sps_in_if and sps_out_if: valid/ready channels of the sieve
// depends on sps_pkg for field widths

interface sps_in_if
    import sps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PRIME_W-1:0] root_prime;
    logic               last_prime;

    modport source (output valid, output root_prime, output last_prime, input ready);
    modport sink (input valid, input root_prime, input last_prime, output ready);
endinterface

interface sps_out_if
    import sps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink (input valid, input prime_count, output ready);
endinterface

[hw/rtl/sps_rem.sv]
// sps_rem: restoring remainder unit, one dividend bit per cycle
// depends on sps_pkg (widths, control and status structs)

module sps_rem
    import sps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  rem_ctl_t           ctl,
    input  logic [BASE_W-1:0]  dividend,
    input  logic [PRIME_W-1:0] divisor,
    output rem_sts_t           sts,
    output logic [PRIME_W-1:0] remainder
);

    localparam int STEP_W = $clog2(BASE_W + 1);

    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [BASE_W-1:0]  shift_reg;
    logic [PRIME_W-1:0] rem_reg;
    logic [PRIME_W-1:0] div_reg;
    logic [PRIME_W:0]   trial;
    logic [PRIME_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, shift_reg[BASE_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = PRIME_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[PRIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                step_reg <= STEP_W'(BASE_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[BASE_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/segmented_prime_sieve_unit.sv]
// segmented_prime_sieve_unit: top level, sequencer, composite bit map and counting sweep
// depends on sps_pkg, sps_in_if / sps_out_if and sps_rem
//
// channel     dir  beat fields               note
// prime_in    in   root_prime, last_prime   one sieving prime per beat
// count_out   out  prime_count              one beat per beat flagged last
// cfg_*       in   cfg_index, cfg_data      plain write, no read-back
//
// an item goes through setup (the remainder in sps_rem, one registered multiply, start and
// offset steps) and then a read-modify-write on the map memory for each marked bit
// a last item adds a sweep that counts the map and clears it
// after reset a clearing pass over the map runs with prime_in.ready low; a pending
// count_out beat holds the sieve only once the next count is ready to be emitted

module segmented_prime_sieve_unit
    import sps_pkg::*;
#(
    parameter int SEG_SIZE = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0]    cfg_data,
    sps_in_if.sink               prime_in,
    sps_out_if.source            count_out
);

    localparam int WORDS = (SEG_SIZE + WORD_W - 1) / WORD_W;
    localparam int WA_W  = $clog2(WORDS);
    localparam int LEN_W = $clog2(SEG_SIZE + 1);
    localparam int CW    = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV   = 4'd1;
    localparam logic [3:0] ST_MAX   = 4'd2;
    localparam logic [3:0] ST_PAR   = 4'd3;
    localparam logic [3:0] ST_OFF   = 4'd4;
    localparam logic [3:0] ST_MRD   = 4'd5;
    localparam logic [3:0] ST_MWR   = 4'd6;
    localparam logic [3:0] ST_SWEEP = 4'd7;
    localparam logic [3:0] ST_DRAIN = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    // configuration
    logic [BASE_W-1:0]   base_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [31:0]         len32;
    logic [LEN_W-1:0]    eff_len;
    logic [1:0]          low_bound;

    // sequencer
    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic                last_reg;
    logic                count_en_reg;
    logic [WA_W-1:0]     sweep_addr_reg;
    logic [1:0]          drain_reg;

    // datapath
    logic [PRIME_W-1:0]  p_reg;
    logic [2*PRIME_W-1:0] pp_reg;
    logic [WIDE_W-1:0]   first_reg;
    logic [WIDE_W-1:0]   start_reg;
    logic [WIDE_W-1:0]   off_reg;
    logic [WIDE_W-1:0]   step;
    logic                off_in_range;
    logic [WA_W-1:0]     mark_word_reg;
    logic [WBIT_W-1:0]   mark_bit_reg;

    // map memory
    logic [WORD_W-1:0]   map_mem [WORDS];
    logic [WORD_W-1:0]   rd_data_reg;
    logic [WA_W-1:0]     mem_raddr;
    logic                mem_we;
    logic [WA_W-1:0]     mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    // counting pipeline
    logic                rd_valid_reg;
    logic [WA_W-1:0]     rd_addr_reg;
    logic                mask_valid_reg;
    logic [WORD_W-1:0]   free_reg;
    logic [WORD_W-1:0]   free_next;
    logic [CW-1:0]       cnt_reg;

    // output slot
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  prime_count_reg;
    logic                emit_fire;

    rem_ctl_t            rem_ctl;
    rem_sts_t            rem_sts;
    logic [PRIME_W-1:0]  rem_value;
    logic                accept;
    logic                skip_item;

    sps_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rem_ctl),
        .dividend  (base_reg),
        .divisor   (prime_in.root_prime),
        .sts       (rem_sts),
        .remainder (rem_value)
    );

    assign len32     = {{(32-LENGTH_W){1'b0}}, length_reg};
    assign eff_len   = (len32 > 32'(SEG_SIZE)) ? LEN_W'(SEG_SIZE) : LEN_W'(len32);
    assign low_bound = (base_reg == '0) ? 2'd2 : ((base_reg == BASE_W'(1)) ? 2'd1 : 2'd0);

    assign prime_in.ready = (state_reg == ST_IDLE);
    assign accept         = prime_in.valid && prime_in.ready;
    assign skip_item      = (prime_in.root_prime < PRIME_W'(2)) || (eff_len == '0);
    assign rem_ctl.start  = accept && !skip_item;

    assign step         = (p_reg == PRIME_W'(2)) ? WIDE_W'(2) : WIDE_W'({p_reg, 1'b0});
    assign off_in_range = off_reg < WIDE_W'(eff_len);
    assign emit_fire    = (state_reg == ST_EMIT) && (!out_valid_reg || count_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEGMENT_BASE:   base_reg   <= cfg_data;
                REG_SEGMENT_LENGTH: length_reg <= cfg_data[LENGTH_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!skip_item)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (prime_in.last_prime)
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_DIV:
            begin
                if (rem_sts.done)
                begin
                    state_next = ST_MAX;
                end
            end
            ST_MAX:   state_next = ST_PAR;
            ST_PAR:   state_next = ST_OFF;
            ST_OFF:   state_next = ST_MRD;
            ST_MRD:
            begin
                if (off_in_range)
                begin
                    state_next = ST_MWR;
                end
                else if (last_reg)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MWR:   state_next = ST_MRD;
            ST_SWEEP:
            begin
                if (sweep_addr_reg == WA_W'(WORDS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == 2'd1)
                begin
                    state_next = count_en_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            count_en_reg   <= 1'b0;
            sweep_addr_reg <= '0;
            drain_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            mask_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= (state_reg == ST_SWEEP) && count_en_reg;
            mask_valid_reg <= rd_valid_reg;
            if (accept)
            begin
                count_en_reg <= 1'b1;
            end
            if (state_reg == ST_SWEEP)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
                drain_reg      <= 2'd2;
            end
            else
            begin
                sweep_addr_reg <= '0;
                if (drain_reg != '0)
                begin
                    drain_reg <= drain_reg - 1'b1;
                end
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (count_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // start of marking: max(p*p, first multiple at or above base), odd for odd p
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg    <= prime_in.root_prime;
            last_reg <= prime_in.last_prime;
        end
        pp_reg <= p_reg * p_reg;
        if (state_reg == ST_DIV && rem_sts.done)
        begin
            if (rem_value == '0)
            begin
                first_reg <= WIDE_W'(base_reg);
            end
            else
            begin
                first_reg <= WIDE_W'(base_reg) + WIDE_W'(p_reg - rem_value);
            end
        end
        case (state_reg)
            ST_MAX:
            begin
                start_reg <= (WIDE_W'(pp_reg) > first_reg) ? WIDE_W'(pp_reg) : first_reg;
            end
            ST_PAR:
            begin
                if (p_reg != PRIME_W'(2) && !start_reg[0])
                begin
                    start_reg <= start_reg + WIDE_W'(p_reg);
                end
            end
            ST_OFF:
            begin
                off_reg <= start_reg - WIDE_W'(base_reg);
            end
            ST_MRD:
            begin
                mark_word_reg <= off_reg[WA_W+WBIT_W-1:WBIT_W];
                mark_bit_reg  <= off_reg[WBIT_W-1:0];
            end
            ST_MWR:
            begin
                off_reg <= off_reg + step;
            end
            default: ;
        endcase
    end

    // map memory with one read and one write port: marks are read-modify-write, the sweep reads and clears
    always_comb
    begin
        mem_raddr = (state_reg == ST_SWEEP) ? sweep_addr_reg
                                            : off_reg[WA_W+WBIT_W-1:WBIT_W];
        mem_we    = 1'b0;
        mem_waddr = sweep_addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_MWR)
        begin
            mem_we    = 1'b1;
            mem_waddr = mark_word_reg;
            mem_wdata = rd_data_reg | (WORD_W'(1) << mark_bit_reg);
        end
        else if (state_reg == ST_SWEEP)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= map_mem[mem_raddr];
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
    end

    // unmarked bits that stand for integers of at least two inside the segment
    always_comb
    begin
        logic [31:0] g;
        for (int j = 0; j < WORD_W; j++)
        begin
            g = {{(32-WA_W-WBIT_W){1'b0}}, rd_addr_reg, WBIT_W'(j)};
            free_next[j] = !rd_data_reg[j] && (g < 32'(eff_len)) && (g >= 32'(low_bound));
        end
    end

    // the count is held while a finished total waits for the output slot
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= sweep_addr_reg;
        free_reg    <= free_next;
        if (state_reg != ST_SWEEP && state_reg != ST_DRAIN && state_reg != ST_EMIT)
        begin
            cnt_reg <= '0;
        end
        else if (mask_valid_reg)
        begin
            cnt_reg <= cnt_reg + CW'($countones(free_reg));
        end
        if (emit_fire)
        begin
            prime_count_reg <= cnt_reg[COUNT_W-1:0];
        end
    end

    assign count_out.valid       = out_valid_reg;
    assign count_out.prime_count = prime_count_reg;

    a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_sts.done |-> state_reg == ST_DIV)
        else $error("remainder finished outside the division step");

    a_mark_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MRD && off_in_range) |=>
            (state_reg == ST_MWR && mark_word_reg <= WA_W'(WORDS - 1)))
        else $error("mark outside the map");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> cnt_reg <= CW'(eff_len))
        else $error("count exceeds segment length");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_sts.busy || state_reg == ST_SWEEP || state_reg == ST_MWR) |-> !prime_in.ready)
        else $error("prime accepted while the sieve is busy");

endmodule

[dv/segmented_prime_sieve_unit_test.sv]
// segmented_prime_sieve_unit_test: self-checking bench for the segmented prime sieve unit
// depends on sps_pkg, sps_in_if / sps_out_if and segmented_prime_sieve_unit;
// a bit-map model of the sieve predicts every prime_count beat

module segmented_prime_sieve_unit_test;
    import sps_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [PRIME_W-1:0] root_prime;
        logic               last_prime;
    } sieve_beat_t;

    typedef enum {SEG_CLEAN, SEG_FAR, SEG_BROKEN, SEG_NOISE} seg_style_t;

    localparam int   SEG_SIZE        = 65536;
    localparam int   STIM_ITEMS      = 1700;
    localparam int   PRIME_TABLE_TOP = 2048;
    localparam int   HOLD_CYCLES     = 25000;
    localparam u64_t CYCLE_LIMIT     = 64'd40000000;
    localparam u64_t BASE_MAX        = 64'h3_FFFF_FFFF;
    localparam u64_t ROOT_MAX        = 64'd131071;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BASE_W-1:0]    cfg_data;

    sps_in_if  prime_ch ();
    sps_out_if count_ch ();

    segmented_prime_sieve_unit #(.SEG_SIZE(SEG_SIZE)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .prime_in  (prime_ch),
        .count_out (count_ch)
    );

    // own copy of the sieve state and registers
    bit [SEG_SIZE-1:0]  composite_bits = '0;
    u64_t               seg_base = 0;
    u64_t               seg_length = 65536;
    int unsigned        small_primes[$];

    sieve_beat_t        prime_backlog[$];
    logic [COUNT_W-1:0] expected_counts[$];

    u64_t        cycles = 0;
    u64_t        busy_until = 0;
    int unsigned items_queued = 0;
    int unsigned beats_accepted = 0;
    int unsigned counts_checked = 0;
    int unsigned fault_count = 0;
    logic        squeeze_req = 1'b0;
    int unsigned hold_left;
    logic        hold_used;
    logic        steady_in;
    logic        steady_out;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    function automatic u64_t live_length();
        return (seg_length > SEG_SIZE) ? u64_t'(SEG_SIZE) : seg_length;
    endfunction

    // strikes the multiples of p in the segment, returns the number of marks
    function automatic u64_t strike_multiples(u64_t p);
        u64_t len;
        u64_t top;
        u64_t first;
        u64_t start;
        u64_t stride;
        u64_t a;
        u64_t n;
        len = live_length();
        top = seg_base + len;
        n = 0;
        if (p < 2 || len == 0)
            return 0;
        first = ((seg_base + p - 1) / p) * p;
        start = p * p;
        if (first > start)
            start = first;
        if (p == 2)
            stride = 2;
        else
        begin
            // odd roots only strike odd multiples
            if (!start[0])
                start += p;
            stride = 2 * p;
        end
        for (a = start; a < top; a += stride)
        begin
            if (a - seg_base < SEG_SIZE)
                composite_bits[a - seg_base] = 1'b1;
            n++;
        end
        return n;
    endfunction

    // counts unmarked positions holding an integer of two or more, then clears the map
    function automatic logic [COUNT_W-1:0] tally_primes();
        u64_t len;
        u64_t i;
        u64_t n;
        len = live_length();
        n = 0;
        for (i = 0; i < len; i++)
            if (seg_base + i >= 2 && !composite_bits[i])
                n++;
        composite_bits = '0;
        return n[COUNT_W-1:0];
    endfunction

    function automatic void build_prime_table();
        bit [PRIME_TABLE_TOP-1:0] crossed;
        int i;
        int j;
        crossed = '0;
        for (i = 2; i < PRIME_TABLE_TOP; i++)
        begin
            if (!crossed[i])
            begin
                small_primes.push_back(i);
                for (j = i * i; j < PRIME_TABLE_TOP; j += i)
                    crossed[j] = 1'b1;
            end
        end
    endfunction

    function automatic u64_t noise_root();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return u64_t'($urandom_range(0, 131071));
        if (r < 65)
            return u64_t'($urandom_range(0, 40));
        return u64_t'(small_primes[$urandom_range(0, small_primes.size() - 1)]);
    endfunction

    // driver: one beat at a time from the backlog, predicting on acceptance
    assign steady_in  = beats_accepted >= 800 && beats_accepted < 1150;
    assign steady_out = counts_checked >= 14 && counts_checked < 24;

    always @(posedge clk or negedge rst_n)
    begin
        sieve_beat_t next_beat;
        u64_t        marks;
        u64_t        cost;
        if (!rst_n)
        begin
            prime_ch.valid      <= 1'b0;
            prime_ch.root_prime <= '0;
            prime_ch.last_prime <= 1'b0;
        end
        else
        begin
            if (prime_ch.valid && prime_ch.ready)
            begin
                marks = strike_multiples(u64_t'(prime_ch.root_prime));
                // rough cost: setup, read-modify-write per mark, count sweep
                cost = 48 + 2 * marks;
                if (prime_ch.last_prime)
                begin
                    expected_counts.push_back(tally_primes());
                    cost += SEG_SIZE / 32 + 8;
                end
                busy_until <= ((busy_until > cycles) ? busy_until : cycles) + cost;
                beats_accepted++;
            end
            if (!prime_ch.valid || prime_ch.ready)
            begin
                if (prime_backlog.size() != 0 && (steady_in || $urandom_range(0, 99) >= 28))
                begin
                    next_beat = prime_backlog.pop_front();
                    prime_ch.valid      <= 1'b1;
                    prime_ch.root_prime <= next_beat.root_prime;
                    prime_ch.last_prime <= next_beat.last_prime;
                end
                else
                    prime_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so that a finished count blocks the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (squeeze_req && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor: every count beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        logic [COUNT_W-1:0] want;
        if (!rst_n)
            count_ch.ready <= 1'b0;
        else
        begin
            if (count_ch.valid && count_ch.ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("count beat %0d with nothing expected: got %0d",
                                 counts_checked, count_ch.prime_count);
                    fault_count++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (count_ch.prime_count !== want)
                    begin
                        if (fault_count < 10)
                            $display("prime_count mismatch on beat %0d: expected %0d, got %0d",
                                     counts_checked, want, count_ch.prime_count);
                        fault_count++;
                    end
                end
                counts_checked++;
            end
            if (hold_left != 0)
                count_ch.ready <= 1'b0;
            else
                count_ch.ready <= steady_out || $urandom_range(0, 99) >= 28;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input u64_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[BASE_W-1:0];
        if (idx == REG_SEGMENT_BASE)
            seg_base = value & BASE_MAX;
        else
            seg_length = u64_t'(value[LENGTH_W-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // waits until every beat is in, every count is out and the block has had time to finish
    // checked on the falling edge, once the rising-edge updates have all landed
    task automatic settle();
        while (prime_backlog.size() != 0 || prime_ch.valid || expected_counts.size() != 0
               || cycles < busy_until)
            @(negedge clk);
        repeat (32) @(posedge clk);
    endtask

    task automatic offer(input u64_t root, input logic last);
        sieve_beat_t b;
        b.root_prime = root[PRIME_W-1:0];
        b.last_prime = last;
        @(negedge clk);
        prime_backlog.push_back(b);
        items_queued++;
    endtask

    task automatic queue_segment(input seg_style_t style);
        sieve_beat_t batch[$];
        sieve_beat_t b;
        u64_t        top;
        int unsigned k;
        int unsigned want;
        int unsigned i;
        top = seg_base + live_length();
        b.last_prime = 1'b0;
        case (style)
            SEG_CLEAN, SEG_BROKEN:
            begin
                foreach (small_primes[j])
                begin
                    if (u64_t'(small_primes[j]) * small_primes[j] >= top)
                        break;
                    if (style == SEG_BROKEN && $urandom_range(0, 99) < 8)
                    begin
                        b.root_prime = PRIME_W'(noise_root());
                        batch.push_back(b);
                    end
                    if (style == SEG_CLEAN || $urandom_range(0, 99) >= 15)
                    begin
                        b.root_prime = PRIME_W'(small_primes[j]);
                        batch.push_back(b);
                    end
                end
                if (style == SEG_BROKEN && $urandom_range(0, 99) < 20)
                    batch.reverse();
            end
            SEG_FAR:
            begin
                k = $urandom_range(0, small_primes.size() - 1);
                want = $urandom_range(4, 24);
                while (k < small_primes.size() && batch.size() < want)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        b.root_prime = PRIME_W'(small_primes[k]);
                        batch.push_back(b);
                    end
                    k++;
                end
                if ($urandom_range(0, 99) < 30)
                begin
                    b.root_prime = PRIME_W'(ROOT_MAX);
                    batch.push_back(b);
                end
            end
            default:
            begin
                want = $urandom_range(1, 8);
                for (i = 0; i < want; i++)
                begin
                    b.root_prime = PRIME_W'(noise_root());
                    b.last_prime = $urandom_range(0, 99) < 15;
                    batch.push_back(b);
                end
            end
        endcase
        if (batch.size() == 0)
        begin
            b.root_prime = PRIME_W'(2);
            b.last_prime = 1'b0;
            batch.push_back(b);
        end
        batch[batch.size() - 1].last_prime = 1'b1;
        @(negedge clk);
        foreach (batch[j])
            prime_backlog.push_back(batch[j]);
        items_queued += batch.size();
    endtask

    task automatic pick_setting(input seg_style_t style);
        u64_t        b;
        u64_t        len;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (style == SEG_FAR)
            b = (u64_t'($urandom_range(0, 3)) << 32) | u64_t'($urandom);
        else if (r < 15)
            b = 0;
        else if (r < 65)
            b = u64_t'($urandom_range(0, 5000));
        else if (r < 85)
            b = u64_t'($urandom_range(0, 200000));
        else
            b = u64_t'($urandom_range(0, 4000000));
        r = $urandom_range(0, 99);
        if (r < 80)
            len = u64_t'($urandom_range(1, 256));
        else if (r < 95)
            len = u64_t'($urandom_range(257, 1024));
        else
            len = u64_t'($urandom_range(1025, 4096));
        settle();
        write_reg(REG_SEGMENT_BASE, b);
        write_reg(REG_SEGMENT_LENGTH, len);
    endtask

    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("segmented_prime_sieve_unit_test: done, errors");
        $finish;
    end

    initial
    begin
        seg_style_t  style;
        int unsigned round;
        int unsigned r;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SEGMENT_BASE;
        cfg_data  <= '0;
        build_prime_table();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // register values after reset, root too large to strike anything
        offer(ROOT_MAX, 1'b1);

        // roots below two, a composite root, zero and one inside the segment
        settle();
        write_reg(REG_SEGMENT_BASE, 0);
        write_reg(REG_SEGMENT_LENGTH, 100);
        offer(0, 1'b0);
        offer(1, 1'b0);
        offer(2, 1'b0);
        offer(3, 1'b0);
        offer(9, 1'b0);
        offer(5, 1'b0);
        offer(7, 1'b1);

        // base moved halfway through a segment, earlier marks stay put
        settle();
        write_reg(REG_SEGMENT_LENGTH, 200);
        offer(2, 1'b0);
        offer(3, 1'b0);
        settle();
        write_reg(REG_SEGMENT_BASE, 150);
        offer(5, 1'b0);
        offer(7, 1'b0);
        offer(11, 1'b0);
        offer(13, 1'b1);

        // empty segment
        settle();
        write_reg(REG_SEGMENT_LENGTH, 0);
        offer(3, 1'b1);

        // top base, length beyond the map size gets cut
        settle();
        write_reg(REG_SEGMENT_BASE, BASE_MAX);
        write_reg(REG_SEGMENT_LENGTH, 64'h1FFFF);
        offer(ROOT_MAX, 1'b1);

        // single-integer segment
        settle();
        write_reg(REG_SEGMENT_LENGTH, 1);
        offer(2, 1'b1);

        round = 0;
        items_queued = 0;
        while (items_queued < STIM_ITEMS)
        begin
            if (round == 3)
            begin
                // three segments back to back against a stalled receiver
                settle();
                write_reg(REG_SEGMENT_BASE, u64_t'($urandom_range(0, 3000)));
                write_reg(REG_SEGMENT_LENGTH, u64_t'($urandom_range(64, 256)));
                @(posedge clk);
                squeeze_req <= 1'b1;
                repeat (3) queue_segment(SEG_CLEAN);
            end
            else if (round == 6)
            begin
                settle();
                write_reg(REG_SEGMENT_BASE, u64_t'($urandom_range(0, 1 << 20)));
                write_reg(REG_SEGMENT_LENGTH, SEG_SIZE);
                queue_segment(SEG_CLEAN);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    style = SEG_CLEAN;
                else if (r < 70)
                    style = SEG_FAR;
                else if (r < 82)
                    style = SEG_BROKEN;
                else
                    style = SEG_NOISE;
                // sometimes keep the registers and run straight on
                if (!(style != SEG_FAR && seg_base <= 4000000 && live_length() <= 4096
                      && $urandom_range(0, 99) < 12))
                    pick_setting(style);
                queue_segment(style);
            end
            round++;
        end

        settle();
        repeat (SEG_SIZE / 32 + 64) @(posedge clk);
        if (fault_count == 0 && expected_counts.size() == 0)
            $display("segmented_prime_sieve_unit_test: done, clean");
        else
            $display("segmented_prime_sieve_unit_test: done, errors");
        $finish;
    end

endmodule
